// ===== src/dvrt_pkg.sv =====
// Package for the distance-vector route table: item kinds, field widths and
// the result record. No dependencies.
`default_nettype none
package dvrt_pkg;
  localparam int unsigned AddrW = 32;
  localparam int unsigned LenW = 6;
  localparam int unsigned DistW = 32;
  localparam int unsigned MissW = 4;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 32;
  localparam logic [MissW-1:0] MissSaturate = 4'd15;
  localparam logic [CfgIdxW-1:0] CfgInfinity = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgMissLimit = 1'b1;

  typedef enum logic [1:0] {
    ModeLoad = 2'd0,
    ModeAdvert = 2'd1,
    ModeTick = 2'd2,
    ModeNone = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StWrite,
    StTick,
    StFull
  } state_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [AddrW-1:0] network;
    logic [LenW-1:0] prefix_len;
    logic [DistW-1:0] distance;
    logic [AddrW-1:0] next_hop;
  } req_t;

  typedef struct packed {
    logic status;
    logic [AddrW-1:0] route_net;
    logic [LenW-1:0] route_len;
    logic [DistW-1:0] route_dist;
    logic [AddrW-1:0] route_via;
    logic is_unreachable;
    logic last;
  } rsp_t;
endpackage
`default_nettype wire

// ===== src/dvrt_if.sv =====
// Valid/ready channel interface carrying one payload of type T.
// Depends on nothing; payload types come from dvrt_pkg.
`default_nettype none
interface dvrt_if #(parameter type T = logic) (input wire logic clk_i);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/dvrt_store.sv =====
// Route store: one synchronous memory holding key, distance and next hop,
// plus per-entry valid, miss and seen flags in flip-flops. Uses dvrt_pkg.
`default_nettype none
module dvrt_store #(
  parameter int unsigned Depth = 32,
  parameter int unsigned IdxW = 5
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic [IdxW-1:0] rd_idx_i,
  output logic [dvrt_pkg::AddrW+dvrt_pkg::LenW+dvrt_pkg::DistW+dvrt_pkg::AddrW-1:0] rd_data_o,
  input  wire logic wr_en_i,
  input  wire logic [IdxW-1:0] wr_idx_i,
  input  wire logic [dvrt_pkg::AddrW+dvrt_pkg::LenW+dvrt_pkg::DistW+dvrt_pkg::AddrW-1:0] wr_data_i,
  input  wire logic flag_we_i,
  input  wire logic [IdxW-1:0] flag_idx_i,
  input  wire logic valid_d_i,
  input  wire logic [dvrt_pkg::MissW-1:0] miss_d_i,
  input  wire logic seen_d_i,
  output logic [Depth-1:0] valid_o,
  output logic [Depth-1:0] seen_o,
  output logic [dvrt_pkg::MissW-1:0] miss_o
);
  import dvrt_pkg::*;
  localparam int unsigned EntW = AddrW + LenW + DistW + AddrW;

  logic [EntW-1:0] mem [Depth];
  logic [Depth-1:0] valid_q, seen_q;
  logic [MissW-1:0] miss_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx_i] <= wr_data_i;
    end
    rd_data_o <= mem[rd_idx_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      seen_q <= '0;
      for (int i = 0; i < Depth; i++) miss_q[i] <= '0;
    end else if (flag_we_i) begin
      valid_q[flag_idx_i] <= valid_d_i;
      seen_q[flag_idx_i] <= seen_d_i;
      miss_q[flag_idx_i] <= miss_d_i;
    end
  end

  assign valid_o = valid_q;
  assign seen_o = seen_q;
  assign miss_o = miss_q[flag_idx_i];
endmodule
`default_nettype wire

// ===== src/distance_vector_route_table_top.sv =====
// Top level of the distance-vector route table: sequencer and output register.
// Depends on dvrt_pkg, dvrt_if and dvrt_store.
//
// Usage. Items arrive on req (valid/ready, type dvrt_pkg::req_t) and results
// leave on rsp (valid/ready, type dvrt_pkg::rsp_t). An item is taken when
// valid and ready are both high at a rising clock edge. Configuration writes
// use cfg_we_i, cfg_idx_i (0 infinity distance, 1 miss limit) and cfg_data_i.
//
// Timing. Every load or advert walks the whole table through the memory's
// single read port, one entry per cycle, to find its key. A tick walks the
// table once more, ageing each valid entry and emitting it, at one entry per
// cycle when the receiver is ready. The memory read port is what sets the
// figure: one entry per cycle.
//
// Reset clears all valid, seen and miss flags at once, so the table is empty
// and usable once reset is released; entry payload needs no clearing.
// A stalled receiver holds the result register and the walk waits on it; no
// new item is taken until all results of the current item are delivered.
`default_nettype none
module distance_vector_route_table_top #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dvrt_if.sink      req,
  dvrt_if.source    rsp,
  input  wire logic cfg_we_i,
  input  wire logic [dvrt_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [dvrt_pkg::CfgDataW-1:0] cfg_data_i
);
  import dvrt_pkg::*;
  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned EntW = AddrW + LenW + DistW + AddrW;
  localparam logic [CntW-1:0] DepthC = CntW'(TABLE_DEPTH);

  // Configuration registers.
  logic [DistW-1:0] inf_q;
  logic [MissW-1:0] lim_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inf_q <= '1;
      lim_q <= 4'd3;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgInfinity:  inf_q <= cfg_data_i;
        CfgMissLimit: lim_q <= cfg_data_i[MissW-1:0];
        default: ;
      endcase
    end
  end

  state_e state_q, state_d;
  req_t item_q;
  logic [CntW-1:0] rd_cnt_q, rd_cnt_d;   // next address issued
  logic [CntW-1:0] cmp_cnt_q, cmp_cnt_d; // entry whose data is on rd_data
  logic cmp_vld_q, cmp_vld_d;
  logic hit_q, hit_d;
  logic [IdxW-1:0] hit_idx_q, hit_idx_d;
  logic [EntW-1:0] hit_ent_q, hit_ent_d;
  rsp_t out_q, out_d;
  logic out_vld_q, out_vld_d;

  logic [EntW-1:0] rd_data;
  logic [TABLE_DEPTH-1:0] valid_v, seen_v;
  logic [MissW-1:0] miss_r;
  logic rd_hold;

  logic wr_en, flag_we, valid_dn, seen_dn;
  logic [IdxW-1:0] wr_idx, flag_idx, rd_idx;
  logic [EntW-1:0] wr_data;
  logic [MissW-1:0] miss_dn;

  // Lowest free slot, a priority search over the valid flip-flops.
  logic free_any;
  logic [IdxW-1:0] free_idx;
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!valid_v[i]) begin
        free_any = 1'b1;
        free_idx = IdxW'(i);
      end
    end
  end

  // Valid slots after the current position decide the last flag of a tick.
  logic [IdxW-1:0] cur_idx;
  logic later_valid;
  assign cur_idx = cmp_cnt_q[IdxW-1:0];
  always_comb begin
    later_valid = 1'b0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (valid_v[i] && (CntW'(i) > cmp_cnt_q)) later_valid = 1'b1;
    end
  end

  dvrt_store #(.Depth(TABLE_DEPTH), .IdxW(IdxW)) u_store (
    .clk_i, .rst_ni,
    .rd_idx_i(rd_idx), .rd_data_o(rd_data),
    .wr_en_i(wr_en), .wr_idx_i(wr_idx), .wr_data_i(wr_data),
    .flag_we_i(flag_we), .flag_idx_i(flag_idx),
    .valid_d_i(valid_dn), .miss_d_i(miss_dn), .seen_d_i(seen_dn),
    .valid_o(valid_v), .seen_o(seen_v), .miss_o(miss_r)
  );

  logic [AddrW-1:0] e_net, e_via;
  logic [LenW-1:0] e_len;
  logic [DistW-1:0] e_dist;
  assign {e_net, e_len, e_dist, e_via} = rd_data;

  logic out_free;
  assign out_free = !out_vld_q || rsp.ready;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (req.valid && !out_vld_q) begin
          unique case (mode_e'(req.data.mode))
            ModeLoad, ModeAdvert: state_d = StScan;
            ModeTick:             state_d = StTick;
            default:              state_d = StIdle;
          endcase
        end
      end
      StScan:  if (cmp_vld_q && (cmp_cnt_q == DepthC - 1'b1)) state_d = StWrite;
      StWrite: state_d = (hit_q || free_any) ? StIdle : StFull;
      StFull:  if (out_free) state_d = StIdle;
      StTick:  if (cmp_vld_q && out_free && (cmp_cnt_q == DepthC - 1'b1)) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    rd_cnt_d = rd_cnt_q;
    cmp_cnt_d = cmp_cnt_q;
    cmp_vld_d = cmp_vld_q;
    hit_d = hit_q;
    hit_idx_d = hit_idx_q;
    hit_ent_d = hit_ent_q;
    out_d = out_q;
    out_vld_d = out_vld_q && !rsp.ready;
    wr_en = 1'b0;
    wr_idx = cur_idx;
    wr_data = rd_data;
    flag_we = 1'b0;
    flag_idx = cur_idx;
    valid_dn = 1'b1;
    seen_dn = 1'b0;
    miss_dn = miss_r;
    rd_hold = 1'b0;
    unique case (state_q)
      StIdle: begin
        rd_cnt_d = '0;
        cmp_vld_d = 1'b0;
        hit_d = 1'b0;
      end
      StScan: begin
        if (cmp_vld_q && valid_v[cur_idx] && e_net == item_q.network &&
            e_len == item_q.prefix_len) begin
          hit_d = 1'b1;
          hit_idx_d = cur_idx;
          hit_ent_d = rd_data;
        end
      end
      StWrite: begin
        if (hit_q) begin
          flag_idx = hit_idx_q;
          wr_idx = hit_idx_q;
          if (item_q.mode == ModeLoad) begin
            wr_en = 1'b1;
            wr_data = {hit_ent_q[EntW-1:DistW+AddrW], item_q.distance, {AddrW{1'b0}}};
          end else begin
            flag_we = 1'b1;
            seen_dn = 1'b1;
            if (item_q.distance < hit_ent_q[DistW+AddrW-1:AddrW]) begin
              wr_en = 1'b1;
              wr_data = {hit_ent_q[EntW-1:DistW+AddrW], item_q.distance,
                         item_q.next_hop};
            end
          end
        end else if (free_any) begin
          wr_en = 1'b1;
          wr_idx = free_idx;
          flag_we = 1'b1;
          flag_idx = free_idx;
          miss_dn = '0;
          seen_dn = (item_q.mode == ModeAdvert);
          wr_data = {item_q.network, item_q.prefix_len, item_q.distance,
                     (item_q.mode == ModeAdvert) ? item_q.next_hop : {AddrW{1'b0}}};
        end
      end
      StFull: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          out_d.status = 1'b1;
          out_d.route_net = item_q.network;
          out_d.route_len = item_q.prefix_len;
          out_d.route_dist = item_q.distance;
          out_d.route_via = (item_q.mode == ModeAdvert) ? item_q.next_hop : '0;
          out_d.is_unreachable = (item_q.distance == inf_q);
          out_d.last = 1'b1;
        end
      end
      StTick: begin
        // The walk stalls while the result register is full and the receiver is not ready.
        if (cmp_vld_q && !out_free) rd_hold = 1'b1;
        if (cmp_vld_q && out_free && valid_v[cur_idx]) begin
          flag_we = 1'b1;
          seen_dn = 1'b0;
          if (seen_v[cur_idx]) begin
            miss_dn = '0;
          end else begin
            miss_dn = (miss_r < MissSaturate) ? miss_r + 1'b1 : miss_r;
          end
          out_vld_d = 1'b1;
          out_d.status = 1'b0;
          out_d.route_net = e_net;
          out_d.route_len = e_len;
          out_d.route_via = e_via;
          out_d.route_dist = e_dist;
          if (!seen_v[cur_idx] && miss_dn >= lim_q) begin
            out_d.route_dist = inf_q;
            wr_en = 1'b1;
            wr_data = {e_net, e_len, inf_q, e_via};
          end
          out_d.is_unreachable = (out_d.route_dist == inf_q);
          out_d.last = !later_valid;
        end
      end
      default: ;
    endcase
    if ((state_q == StScan || state_q == StTick) && !rd_hold) begin
      cmp_vld_d = (rd_cnt_q < DepthC);
      cmp_cnt_d = rd_cnt_q;
      if (rd_cnt_q < DepthC) rd_cnt_d = rd_cnt_q + 1'b1;
    end
  end

  // Read address: hold the current entry while the walk is stalled.
  assign rd_idx = rd_hold ? cur_idx : rd_cnt_q[IdxW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      rd_cnt_q <= '0;
      cmp_cnt_q <= '0;
      cmp_vld_q <= 1'b0;
      hit_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_cnt_q <= rd_cnt_d;
      cmp_cnt_q <= cmp_cnt_d;
      cmp_vld_q <= cmp_vld_d;
      hit_q <= hit_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_idx_q <= hit_idx_d;
    hit_ent_q <= hit_ent_d;
    out_q <= out_d;
    if (req.valid && req.ready) item_q <= req.data;
  end

  assign req.ready = (state_q == StIdle) && !out_vld_q;
  assign rsp.valid = out_vld_q;
  assign rsp.data = out_q;
endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the distance-vector route table.
// Depends on dvrt_pkg, dvrt_if and distance_vector_route_table_top.
`timescale 1ns / 1ps
module tb_top;
  import dvrt_pkg::*;

  localparam int unsigned Depth = 32;
  localparam int unsigned WatchdogLimit = 200000;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  dvrt_if #(.T(req_t)) req (.clk_i(clk_i));
  dvrt_if #(.T(rsp_t)) rsp (.clk_i(clk_i));

  distance_vector_route_table_top #(.TABLE_DEPTH(Depth)) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .req(req),
    .rsp(rsp),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // The clock runs with a 4 ns period.
  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Shadow copy of the route table and its registers, used for prediction.
  logic [DistW-1:0] inf_dist;
  logic [MissW-1:0] miss_lim;
  logic             tbl_valid [Depth];
  logic [AddrW-1:0] tbl_net   [Depth];
  logic [LenW-1:0]  tbl_len   [Depth];
  logic [DistW-1:0] tbl_dist  [Depth];
  logic [AddrW-1:0] tbl_via   [Depth];
  logic [MissW-1:0] tbl_miss  [Depth];
  logic             tbl_seen  [Depth];

  rsp_t expected_routes[$];
  int   mismatches;
  int   idle_cycles;
  int   send_idle_pct;
  int   recv_idle_pct;
  bit   hold_off;

  // Build one result record; the unreachable flag follows the current infinity.
  function automatic rsp_t make_route(logic st, logic [AddrW-1:0] net,
                                      logic [LenW-1:0] len, logic [DistW-1:0] dist_v,
                                      logic [AddrW-1:0] via, logic lst);
    rsp_t r;
    r.status = st;
    r.route_net = net;
    r.route_len = len;
    r.route_dist = dist_v;
    r.route_via = via;
    r.is_unreachable = (dist_v == inf_dist);
    r.last = lst;
    return r;
  endfunction

  // Append one expected route to the tail of the queue.
  function automatic void queue_route(rsp_t r);
    expected_routes = {expected_routes, r};
  endfunction

  // Apply one accepted item to the shadow table and queue the routes it emits.
  task automatic predict_routes(req_t it);
    int hit;
    int slot;
    int last_slot;
    logic [AddrW-1:0] via;
    hit = -1;
    slot = -1;
    last_slot = -1;
    if (it.mode == ModeLoad || it.mode == ModeAdvert) begin
      via = (it.mode == ModeAdvert) ? it.next_hop : '0;
      for (int i = 0; i < Depth; i++) begin
        if (hit < 0 && tbl_valid[i] && tbl_net[i] == it.network &&
            tbl_len[i] == it.prefix_len) hit = i;
        if (slot < 0 && !tbl_valid[i]) slot = i;
      end
      if (hit >= 0) begin
        // A load always overwrites; an advert only when strictly better.
        if (it.mode == ModeLoad || it.distance < tbl_dist[hit]) begin
          tbl_dist[hit] = it.distance;
          tbl_via[hit] = via;
        end
        if (it.mode == ModeAdvert) tbl_seen[hit] = 1'b1;
      end else if (slot < 0) begin
        queue_route(make_route(1'b1, it.network, it.prefix_len,
                               it.distance, via, 1'b1));
      end else begin
        tbl_valid[slot] = 1'b1;
        tbl_net[slot] = it.network;
        tbl_len[slot] = it.prefix_len;
        tbl_dist[slot] = it.distance;
        tbl_via[slot] = via;
        tbl_miss[slot] = '0;
        tbl_seen[slot] = (it.mode == ModeAdvert);
      end
    end else if (it.mode == ModeTick) begin
      for (int i = 0; i < Depth; i++) begin
        if (tbl_valid[i]) begin
          if (tbl_seen[i]) begin
            tbl_miss[i] = '0;
          end else begin
            if (tbl_miss[i] != MissSaturate) tbl_miss[i] = tbl_miss[i] + 1'b1;
            if (tbl_miss[i] >= miss_lim) tbl_dist[i] = inf_dist;
          end
          tbl_seen[i] = 1'b0;
          last_slot = i;
        end
      end
      for (int i = 0; i < Depth; i++) begin
        if (tbl_valid[i]) begin
          queue_route(make_route(1'b0, tbl_net[i], tbl_len[i],
                                 tbl_dist[i], tbl_via[i], i == last_slot));
        end
      end
    end
  endtask

  // Offer one item at the falling edge and wait until the block takes it.
  task automatic send_item(logic [1:0] mode, logic [AddrW-1:0] net,
                           logic [LenW-1:0] len, logic [DistW-1:0] dist_v,
                           logic [AddrW-1:0] hop);
    req_t it;
    it.mode = mode;
    it.network = net;
    it.prefix_len = len;
    it.distance = dist_v;
    it.next_hop = hop;
    do @(negedge clk_i); while ($urandom_range(99, 0) < send_idle_pct);
    req.valid <= 1'b1;
    req.data <= it;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    predict_routes(it);
    @(negedge clk_i);
    req.valid <= 1'b0;
  endtask

  // Wait until every queued route has come out, then let the block settle.
  task automatic drain_routes();
    while (expected_routes.size() != 0) @(negedge clk_i);
    repeat (Depth + 8) @(negedge clk_i);
  endtask

  // Registers change only while the block is idle.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    drain_routes();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgInfinity) inf_dist = val;
    else miss_lim = val[MissW-1:0];
  endtask

  // Receiver: randomly lowers ready, and honors the long hold-off request.
  always @(negedge clk_i) begin
    if (!rst_ni) rsp.ready <= 1'b0;
    else rsp.ready <= !hold_off && ($urandom_range(99, 0) >= recv_idle_pct);
  end

  // Check each accepted route against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (expected_routes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected route out: %p", rsp.data);
      end else begin
        rsp_t exp_r;
        exp_r = expected_routes.pop_front();
        if (rsp.data !== exp_r) begin
          mismatches++;
          if (mismatches <= 10) $display("Route mismatch: expected %p, got %p",
                                         exp_r, rsp.data);
        end
      end
    end
  end

  // Watchdog: counts cycles with no handshake on either channel.
  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Directed extremes: full keys, prefix edges, modes, and advert rules.
  task automatic test_directed();
    send_item(ModeLoad, 32'h0000_0000, 6'd0, 32'd0, 32'hFFFF_FFFF);
    send_item(ModeLoad, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, 32'h0);
    send_item(ModeAdvert, 32'h0A00_0000, 6'd8, 32'd10, 32'hC0A8_0001);
    send_item(ModeAdvert, 32'h0A00_0000, 6'd8, 32'd10, 32'h1111_1111); // equal: kept
    send_item(ModeAdvert, 32'h0A00_0000, 6'd8, 32'd9, 32'h2222_2222);  // better
    send_item(ModeAdvert, 32'h0A00_0000, 6'd8, 32'd50, 32'h3333_3333); // worse
    send_item(ModeLoad, 32'h0A00_0000, 6'd8, 32'd70, 32'h4444_4444);   // overwrite
    send_item(ModeAdvert, 32'h0A00_0000, 6'd16, 32'd1, 32'hAAAA_5555);
    send_item(ModeNone, 32'h1234_5678, 6'd32, 32'd5, 32'd5);           // ignored
    send_item(ModeTick, '0, '0, '0, '0);
    for (int t = 0; t < 5; t++) send_item(ModeTick, '1, '1, '1, '1);
  endtask

  // Fill the table and push inserts into it so they are dropped.
  task automatic test_table_full();
    for (int i = 0; i < Depth + 3; i++)
      send_item(i[0] ? ModeAdvert : ModeLoad, $urandom(), 6'($urandom_range(63, 0)),
                $urandom(), $urandom());
    send_item(ModeTick, '0, '0, '0, '0);
    send_item(ModeAdvert, $urandom(), 6'd24, 32'hFFFF_FFFF, 32'h0);
  endtask

  // Keys from a small pool so adverts hit existing routes and ticks age them.
  task automatic test_random(int n);
    logic [AddrW-1:0] net;
    int kind;
    for (int i = 0; i < n; i++) begin
      net = {$urandom_range(7, 0) << 8} | 32'hC0A8_0000;
      kind = $urandom_range(99, 0);
      if (kind < 30) send_item(ModeLoad, net, 6'($urandom_range(24, 22)),
                               $urandom_range(100, 0), $urandom());
      else if (kind < 75) send_item(ModeAdvert, net, 6'($urandom_range(24, 22)),
                                    $urandom_range(100, 0), $urandom());
      else if (kind < 95) send_item(ModeTick, $urandom(), '0, '0, '0);
      else send_item(2'($urandom_range(3, 0)), $urandom(), 6'($urandom_range(63, 0)),
                     $urandom(), $urandom());
    end
  endtask

  // Hold the receiver off while items keep coming, so the input stalls.
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(negedge clk_i);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 6; i++) send_item(ModeTick, '0, '0, '0, '0);
    join
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    req.valid = 1'b0;
    req.data = '0;
    hold_off = 1'b0;
    mismatches = 0;
    idle_cycles = 0;
    inf_dist = 32'hFFFF_FFFF;
    miss_lim = 4'd3;
    for (int i = 0; i < Depth; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_miss[i] = '0;
      tbl_seen[i] = 1'b0;
    end
    send_idle_pct = 32;
    recv_idle_pct = 66;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    write_reg(CfgMissLimit, 32'd1);
    write_reg(CfgInfinity, 32'd0);
    test_random(60);
    write_reg(CfgMissLimit, 32'd15);
    write_reg(CfgInfinity, 32'd16);
    send_idle_pct = 66;
    recv_idle_pct = 32;
    test_random(60);
    write_reg(CfgMissLimit, 32'd0);
    test_random(20);
    write_reg(CfgMissLimit, 32'd2);
    write_reg(CfgInfinity, 32'hFFFF_FFFF);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random(60);
    test_table_full();
    test_random(20);
    drain_routes();

    if (mismatches == 0 && expected_routes.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
